[rtl/crr_pkg.sv]
package crr_pkg;

   // Transaction op codes
   localparam logic [1:0] OP_BUS  = 2'd0;
   localparam logic [1:0] OP_KNOB = 2'd1;
   localparam logic [1:0] OP_LOAD = 2'd2;

   // Boot progress codes; anything at or above BOOT_DONE counts as done
   localparam logic [1:0] BOOT_WAIT_LO = 2'd0;
   localparam logic [1:0] BOOT_WAIT_HI = 2'd1;
   localparam logic [1:0] BOOT_DONE    = 2'd2;

   // Bus phase codes; any code other than BUS_WAIT_DESEL serves
   localparam logic [1:0] BUS_SERVE      = 2'd0;
   localparam logic [1:0] BUS_WAIT_DESEL = 2'd1;

   // Store address width covers every legal depth (20480 to 32768)
   localparam int STORE_AW = 15;

   typedef logic [STORE_AW-1:0] store_addr_type;

   // Store write port bundle
   typedef struct packed {
      logic           en;
      store_addr_type addr;
      logic [7:0]     data;
   } store_wr_type;

   localparam logic [15:0]    VEC_LO_ADDR     = 16'hFFFC;
   localparam logic [15:0]    VEC_HI_ADDR     = 16'hFFFD;
   localparam logic [7:0]     VEC_LO_BYTE     = 8'h00;
   localparam logic [7:0]     VEC_HI_BYTE     = 8'h88;
   localparam store_addr_type ALIAS_LO        = 15'h7FEA;
   localparam store_addr_type ALIAS_HI        = 15'h7FEB;
   localparam store_addr_type ALIAS_LO_TARGET = 15'h4FEA;
   localparam store_addr_type ALIAS_HI_TARGET = 15'h4FEB;
   localparam logic [7:0]     VOL_FLOOR       = 8'h0F;

   // First of the two store bytes that hold each pitch knob
   function automatic store_addr_type pitch_base(input logic [1:0] k);
      store_addr_type a;
      case (k)
         2'd0:    a = 15'h4404;
         2'd1:    a = 15'h440F;
         2'd2:    a = 15'h441A;
         default: a = 15'h4425;
      endcase
      return a;
   endfunction

   // First of the two store bytes that hold each volume knob
   function automatic store_addr_type volume_base(input logic [1:0] k);
      store_addr_type a;
      case (k)
         2'd0:    a = 15'h4402;
         2'd1:    a = 15'h440D;
         2'd2:    a = 15'h4418;
         default: a = 15'h4423;
      endcase
      return a;
   endfunction

endpackage

[rtl/crr_if.sv]
interface crr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] bus_address;
   logic        cart_deselected;
   logic [2:0]  knob_channel;
   logic [11:0] knob_sample;
   logic [14:0] load_address;
   logic [7:0]  load_data;

   modport source (
      output valid, op, bus_address, cart_deselected, knob_channel, knob_sample,
             load_address, load_data,
      input  ready
   );
   modport sink (
      input  valid, op, bus_address, cart_deselected, knob_channel, knob_sample,
             load_address, load_data,
      output ready
   );
endinterface

interface crr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       cart_to_console;
   logic       boot_done;
   logic       knobs_applied;

   modport source (
      output valid, data_out, cart_to_console, boot_done, knobs_applied,
      input  ready
   );
   modport sink (
      input  valid, data_out, cart_to_console, boot_done, knobs_applied,
      output ready
   );
endinterface

[rtl/crr_store.sv]
module crr_store import crr_pkg::*; #(
   parameter int STORE_DEPTH = 20480
) (
   input  logic           clock,
   input  store_wr_type   wr,
   input  logic           rd_en,
   input  store_addr_type rd_addr,
   output logic [7:0]     rd_data
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // Write one byte per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/crr_knob.sv]
module crr_knob import crr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic [2:0]     wr_channel,
   input  logic [11:0]    wr_sample,
   input  logic [3:0]     step,
   output store_addr_type patch_addr,
   output logic [7:0]     patch_data
);

   logic [11:0] knob_ff [8];
   logic [2:0]  ch;
   logic        half;
   logic [11:0] v;
   logic [8:0]  pitch;

   // Hold raw samples, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            knob_ff[i] <= '0;
         end
      end else if (wr_en) begin
         knob_ff[wr_channel] <= wr_sample;
      end
   end

   // Map patch step to one store byte: step bits 3:1 pick the knob, bit 0 the byte
   always_comb begin
      ch    = step[3:1];
      half  = step[0];
      v     = ~knob_ff[ch];
      pitch = v[11:3];
      if (!ch[2]) begin
         patch_addr = pitch_base(ch[1:0]) + {14'd0, half};
         patch_data = half ? {7'd0, pitch[8]} : pitch[7:0];
      end else begin
         patch_addr = volume_base(ch[1:0]) + {14'd0, half};
         patch_data = {1'b0, v[11:5]} | VOL_FLOOR;
      end
   end

endmodule

[rtl/cartridge_rom_responder_with_knob_patch.sv]
// Cartridge ROM responder with knob patch.
// Input channel req_chan carries one transaction per op: a bus sample (address
// and select), a knob sample update, or a store load byte. Output channel
// rsp_chan returns exactly one transaction per request: the byte driven on the
// data bus, transceiver direction, boot status and a patch-applied flag.
// Sequence: an ordinary transaction is accepted and decoded in ST_IDLE (issuing
// the store read), then ST_FINISH captures the store's registered read data
// into the result register once it is free. The deselect sample that follows
// a read of offset 0x7FEB goes through ST_PATCH first: the sixteen knob bytes
// are written back through the store's single write port, one per cycle.
// One request is in flight at a time; a new one is taken as soon as the
// result register is loaded, even while that result waits to be taken.
// A stalled receiver holds the result; the block then waits with its own
// result before loading the next one.
// Reset (synchronous, active high) clears boot and bus phases, the held byte
// and the knob samples, and points the transceiver toward the console. The
// store is not cleared; load it with store load transactions before reading.
module cartridge_rom_responder_with_knob_patch import crr_pkg::*; #(
   parameter int STORE_DEPTH = 20480,
   parameter int SERVE_LIMIT = 20479
) (
   input  logic      clock,
   input  logic      reset,
   crr_req_if.sink   req_chan,
   crr_rsp_if.source rsp_chan
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PATCH  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [15:0]    DEPTH_LIM = 16'(STORE_DEPTH);
   localparam store_addr_type SERVE_LIM = 15'(SERVE_LIMIT);

   logic [1:0] state_ff, state_in;
   logic [1:0] boot_ff, boot_in;
   logic [1:0] bus_ff, bus_in;
   logic [7:0] held_ff, held_in;
   logic       dir_ff, dir_in;
   logic       applied_ff, applied_in;
   logic       rd_pend_ff, rd_pend_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       out_dir_ff, out_dir_in;
   logic       out_boot_ff, out_boot_in;
   logic       out_applied_ff, out_applied_in;

   logic           accept;
   logic           out_load;
   logic [7:0]     sel_data;
   store_addr_type off;
   store_wr_type   wr;
   logic           rd_en;
   store_addr_type rd_addr;
   logic [7:0]     rd_data;
   logic           knob_wr;
   store_addr_type patch_addr;
   logic [7:0]     patch_data;

   crr_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   crr_knob u_knob (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (knob_wr),
      .wr_channel (req_chan.knob_channel),
      .wr_sample  (req_chan.knob_sample),
      .step       (step_ff),
      .patch_addr (patch_addr),
      .patch_data (patch_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign off            = req_chan.bus_address[14:0];
   assign knob_wr        = accept && (req_chan.op == OP_KNOB);
   assign sel_data       = rd_pend_ff ? rd_data : held_ff;

   // Decode transactions, sequence the patch and load the result register
   always_comb begin
      state_in       = state_ff;
      boot_in        = boot_ff;
      bus_in         = bus_ff;
      held_in        = held_ff;
      dir_in         = dir_ff;
      applied_in     = applied_ff;
      rd_pend_in     = rd_pend_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_data_in    = out_data_ff;
      out_dir_in     = out_dir_ff;
      out_boot_in    = out_boot_ff;
      out_applied_in = out_applied_ff;
      out_load       = 1'b0;
      wr.en          = 1'b0;
      wr.addr        = req_chan.load_address;
      wr.data        = req_chan.load_data;
      rd_en          = 1'b0;
      rd_addr        = off;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_FINISH;
               applied_in = 1'b0;
               rd_pend_in = 1'b0;
               case (req_chan.op)
                  OP_LOAD: begin
                     wr.en = ({1'b0, req_chan.load_address} < DEPTH_LIM);
                  end
                  OP_BUS: begin
                     if (boot_ff == BOOT_WAIT_LO) begin
                        if (req_chan.bus_address == VEC_LO_ADDR) begin
                           held_in = VEC_LO_BYTE;
                           boot_in = BOOT_WAIT_HI;
                        end
                     end else if (boot_ff == BOOT_WAIT_HI) begin
                        if (req_chan.bus_address == VEC_HI_ADDR) begin
                           held_in = VEC_HI_BYTE;
                           boot_in = BOOT_DONE;
                        end
                     end else if (bus_ff == BUS_WAIT_DESEL) begin
                        // First deselected sample starts the patch
                        if (req_chan.cart_deselected) begin
                           dir_in     = 1'b0;
                           bus_in     = BUS_SERVE;
                           applied_in = 1'b1;
                           step_in    = '0;
                           state_in   = ST_PATCH;
                        end
                     end else if (req_chan.cart_deselected) begin
                        dir_in = 1'b0;
                     end else begin
                        dir_in = 1'b1;
                        if (off < SERVE_LIM) begin
                           if ({1'b0, off} < DEPTH_LIM) begin
                              rd_en      = 1'b1;
                              rd_pend_in = 1'b1;
                           end else begin
                              held_in = '0;
                           end
                        end else if (off == ALIAS_LO) begin
                           rd_en      = 1'b1;
                           rd_addr    = ALIAS_LO_TARGET;
                           rd_pend_in = 1'b1;
                        end else if (off == ALIAS_HI) begin
                           rd_en      = 1'b1;
                           rd_addr    = ALIAS_HI_TARGET;
                           rd_pend_in = 1'b1;
                           bus_in     = BUS_WAIT_DESEL;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PATCH: begin
            // Write one knob byte per cycle
            wr.en   = 1'b1;
            wr.addr = patch_addr;
            wr.data = patch_data;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'hF) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            held_in    = sel_data;
            rd_pend_in = 1'b0;
            out_load   = !rsp_valid_ff || rsp_chan.ready;
            if (out_load) begin
               rsp_valid_in   = 1'b1;
               out_data_in    = sel_data;
               out_dir_in     = dir_ff;
               out_boot_in    = (boot_ff >= BOOT_DONE);
               out_applied_in = applied_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and held byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         boot_ff      <= BOOT_WAIT_LO;
         bus_ff       <= BUS_SERVE;
         held_ff      <= '0;
         dir_ff       <= 1'b1;
         applied_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         bus_ff       <= bus_in;
         held_ff      <= held_in;
         dir_ff       <= dir_in;
         applied_ff   <= applied_in;
         rd_pend_ff   <= rd_pend_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      out_data_ff    <= out_data_in;
      out_dir_ff     <= out_dir_in;
      out_boot_ff    <= out_boot_in;
      out_applied_ff <= out_applied_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.data_out        = out_data_ff;
   assign rsp_chan.cart_to_console = out_dir_ff;
   assign rsp_chan.boot_done       = out_boot_ff;
   assign rsp_chan.knobs_applied   = out_applied_ff;

endmodule

[rtl/crr_checker.sv]
module crr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] data_out,
   input logic       cart_to_console,
   input logic       boot_done,
   input logic       knobs_applied
);

   // One request in flight: no transaction accepted in back-to-back cycles
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !(req_valid && req_ready))
      else $error("request accepted in consecutive cycles");

   // A patch is reported only with the transceiver turned toward the cartridge
   a_patch_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && knobs_applied) |-> (!cart_to_console && boot_done))
      else $error("patch reported outside deselect or before boot");

   // Boot status never falls back once reported
   a_boot_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && boot_done) |=> (!rsp_valid || boot_done))
      else $error("boot status fell back");

   // A stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its byte
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(data_out))
      else $error("result byte changed while stalled");

endmodule

bind cartridge_rom_responder_with_knob_patch crr_checker u_crr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .data_out        (rsp_chan.data_out),
   .cart_to_console (rsp_chan.cart_to_console),
   .boot_done       (rsp_chan.boot_done),
   .knobs_applied   (rsp_chan.knobs_applied)
);

[dv/cart_reply_checker.sv]
`timescale 1ns / 1ps

module cart_reply_checker import crr_pkg::*; #(
   parameter int STORE_DEPTH = 20480,
   parameter int SERVE_LIMIT = 20479
) (
   input  logic clock,
   input  logic reset,
   crr_req_if   req_mon,
   crr_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   replies_owed,
   output int   patches_seen
);

   typedef struct packed {
      logic [7:0] data_out;
      logic       cart_to_console;
      logic       boot_done;
      logic       knobs_applied;
   } cart_reply_type;

   // Store slots rewritten by the knob patch, two bytes each
   localparam logic [3:0][14:0] PITCH_SLOT  = {15'h4425, 15'h441A, 15'h440F, 15'h4404};
   localparam logic [3:0][14:0] VOLUME_SLOT = {15'h4423, 15'h4418, 15'h440D, 15'h4402};

   // Shadow of the responder state
   logic [7:0]  rom_image [STORE_DEPTH];
   logic [11:0] knob_raw [8];
   logic [1:0]  boot_state;
   logic [1:0]  bus_state;
   logic [7:0]  driven_byte;
   logic        toward_console;

   cart_reply_type pending_replies [$];
   int             errors = 0;
   int             patches = 0;

   assign mismatch_count = errors;
   assign patches_seen   = patches;

   function automatic void poke_rom(input int idx, input logic [7:0] value);
      if (idx < STORE_DEPTH) rom_image[idx] = value;
   endfunction

   function automatic logic [7:0] peek_rom(input int idx);
      if (idx < STORE_DEPTH) return rom_image[idx];
      return 8'h00;
   endfunction

   // Write the inverted knob levels into the sixteen patch bytes
   function automatic void rewrite_knob_bytes();
      logic [11:0] level;
      logic [8:0]  pitch;
      logic [7:0]  loudness;
      for (int k = 0; k < 4; k++) begin
         level = ~knob_raw[k];
         pitch = level[11:3];
         poke_rom(PITCH_SLOT[k], pitch[7:0]);
         poke_rom(PITCH_SLOT[k] + 1, {7'd0, pitch[8]});
         level = ~knob_raw[k + 4];
         loudness = {1'b0, level[11:5]} | VOL_FLOOR;
         poke_rom(VOLUME_SLOT[k], loudness);
         poke_rom(VOLUME_SLOT[k] + 1, loudness);
      end
   endfunction

   // Advance the bus side for one sampled address; return 1 when the patch ran
   function automatic logic take_bus_sample(input logic [15:0] addr, input logic desel);
      logic [14:0] off;
      off = addr[14:0];
      if (boot_state == BOOT_WAIT_LO) begin
         if (addr == VEC_LO_ADDR) begin
            driven_byte = VEC_LO_BYTE;
            boot_state  = BOOT_WAIT_HI;
         end
         return 1'b0;
      end
      if (boot_state == BOOT_WAIT_HI) begin
         if (addr == VEC_HI_ADDR) begin
            driven_byte = VEC_HI_BYTE;
            boot_state  = BOOT_DONE;
         end
         return 1'b0;
      end
      // Waiting for deselect after the last alias byte
      if (bus_state == BUS_WAIT_DESEL) begin
         if (!desel) return 1'b0;
         toward_console = 1'b0;
         rewrite_knob_bytes();
         bus_state = BUS_SERVE;
         return 1'b1;
      end
      if (desel) begin
         toward_console = 1'b0;
         return 1'b0;
      end
      toward_console = 1'b1;
      if (off < SERVE_LIMIT) begin
         driven_byte = peek_rom(off);
      end else if (off == ALIAS_LO) begin
         driven_byte = peek_rom(ALIAS_LO_TARGET);
      end else if (off == ALIAS_HI) begin
         driven_byte = peek_rom(ALIAS_HI_TARGET);
         bus_state   = BUS_WAIT_DESEL;
      end
      return 1'b0;
   endfunction

   function automatic cart_reply_type predict_reply(
      input logic [1:0]  op,
      input logic [15:0] addr,
      input logic        desel,
      input logic [2:0]  chan,
      input logic [11:0] sample,
      input logic [14:0] load_addr,
      input logic [7:0]  load_byte
   );
      cart_reply_type reply;
      logic           applied;
      applied = 1'b0;
      case (op)
         OP_BUS:  applied = take_bus_sample(addr, desel);
         OP_KNOB: knob_raw[chan] = sample;
         OP_LOAD: poke_rom(load_addr, load_byte);
         default: ;
      endcase
      reply.data_out        = driven_byte;
      reply.cart_to_console = toward_console;
      reply.boot_done       = (boot_state >= BOOT_DONE);
      reply.knobs_applied   = applied;
      return reply;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         errors++;
      end
   endtask

   // Compare retired replies first, then queue the prediction for a new request
   always @(posedge clock) begin : watch
      cart_reply_type want;
      if (reset) begin
         for (int k = 0; k < 8; k++) knob_raw[k] = 12'd0;
         boot_state     = BOOT_WAIT_LO;
         bus_state      = BUS_SERVE;
         driven_byte    = 8'h00;
         toward_console = 1'b1;
         pending_replies.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_replies.size() == 0) begin
               $error("reply: none expected, actual data_out %0h", rsp_mon.data_out);
               errors++;
            end else begin
               want = pending_replies.pop_front();
               check_field("data_out", want.data_out, rsp_mon.data_out);
               check_field("cart_to_console", {7'd0, want.cart_to_console},
                           {7'd0, rsp_mon.cart_to_console});
               check_field("boot_done", {7'd0, want.boot_done},
                           {7'd0, rsp_mon.boot_done});
               check_field("knobs_applied", {7'd0, want.knobs_applied},
                           {7'd0, rsp_mon.knobs_applied});
               if (want.knobs_applied) patches++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_replies.push_back(predict_reply(req_mon.op, req_mon.bus_address,
               req_mon.cart_deselected, req_mon.knob_channel, req_mon.knob_sample,
               req_mon.load_address, req_mon.load_data));
         end
      end
      replies_owed <= pending_replies.size();
   end

endmodule

[dv/tb_cartridge_rom_responder_with_knob_patch.sv]
`timescale 1ns / 1ps

module tb_cartridge_rom_responder_with_knob_patch;
   import crr_pkg::*;

   localparam int STORE_DEPTH = 20480;
   localparam int SERVE_LIMIT = 20479;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 275;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;

   crr_req_if req_chan();
   crr_rsp_if rsp_chan();

   int mismatch_count;
   int replies_owed;
   int patches_seen;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int total_sent = 0;
   int sent_by_op [4] = '{0, 0, 0, 0};

   // Store entries that hold a known byte; reads stay inside this set
   bit          loaded [32768];
   logic [14:0] loaded_offsets [$];

   cartridge_rom_responder_with_knob_patch #(
      .STORE_DEPTH (STORE_DEPTH),
      .SERVE_LIMIT (SERVE_LIMIT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cart_reply_checker #(
      .STORE_DEPTH (STORE_DEPTH),
      .SERVE_LIMIT (SERVE_LIMIT)
   ) i_reply_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .replies_owed   (replies_owed),
      .patches_seen   (patches_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_cartridge_rom_responder_with_knob_patch: FAIL");
      $finish;
   end

   // Stall the reply side at the current rate
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Hold one request until the handshake completes
   task automatic send_item(
      input logic [1:0]  op,
      input logic [15:0] addr,
      input logic        desel,
      input logic [2:0]  chan,
      input logic [11:0] sample,
      input logic [14:0] load_addr,
      input logic [7:0]  load_byte
   );
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.op              <= op;
      req_chan.bus_address     <= addr;
      req_chan.cart_deselected <= desel;
      req_chan.knob_channel    <= chan;
      req_chan.knob_sample     <= sample;
      req_chan.load_address    <= load_addr;
      req_chan.load_data       <= load_byte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_by_op[op]++;
      total_sent++;
   endtask

   // Fields that an op ignores carry random values
   task automatic bus_sample(input logic [15:0] addr, input logic desel);
      send_item(OP_BUS, addr, desel, 3'($urandom), 12'($urandom), 15'($urandom),
                8'($urandom));
   endtask

   task automatic knob_update(input logic [2:0] chan, input logic [11:0] sample);
      send_item(OP_KNOB, 16'($urandom), 1'($urandom), chan, sample, 15'($urandom),
                8'($urandom));
   endtask

   task automatic store_load(input logic [14:0] load_addr, input logic [7:0] load_byte);
      send_item(OP_LOAD, 16'($urandom), 1'($urandom), 3'($urandom), 12'($urandom),
                load_addr, load_byte);
      if (load_addr < STORE_DEPTH && !loaded[load_addr]) begin
         loaded[load_addr] = 1'b1;
         if (load_addr < SERVE_LIMIT) loaded_offsets.push_back(load_addr);
      end
   endtask

   task automatic unused_op();
      send_item(OP_UNUSED, 16'($urandom), 1'($urandom), 3'($urandom), 12'($urandom),
                15'($urandom), 8'($urandom));
   endtask

   // Selected read; fill the entry first if it was never written
   task automatic bus_read(input logic [15:0] addr);
      logic [14:0] off;
      off = addr[14:0];
      if (off < SERVE_LIMIT && !loaded[off])
         store_load(off, 8'($urandom));
      else if (off == ALIAS_LO && !loaded[ALIAS_LO_TARGET])
         store_load(ALIAS_LO_TARGET, 8'($urandom));
      else if (off == ALIAS_HI && !loaded[ALIAS_HI_TARGET])
         store_load(ALIAS_HI_TARGET, 8'($urandom));
      bus_sample(addr, 1'b0);
   endtask

   function automatic logic [14:0] knob_byte_address();
      logic [1:0] k;
      k = 2'($urandom);
      if ($urandom_range(0, 1)) return pitch_base(k) + 15'($urandom_range(0, 1));
      return volume_base(k) + 15'($urandom_range(0, 1));
   endfunction

   // Mostly known entries, some fresh ones, some past the served range, some knob bytes
   function automatic logic [15:0] pick_read_address();
      logic [14:0] off;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5:
            off = loaded_offsets[$urandom_range(0, loaded_offsets.size() - 1)];
         6, 7:    off = 15'($urandom_range(0, SERVE_LIMIT - 1));
         8:       off = 15'($urandom_range(SERVE_LIMIT, 32767));
         default: off = knob_byte_address();
      endcase
      return {1'($urandom), off};
   endfunction

   // Stop sending and wait for every owed reply plus a settling tail
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_stall);
      int start;
      start     = total_sent;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      while (total_sent - start < PHASE_ITEMS) begin
         case ($urandom_range(0, 99)) inside
            // full alias read, wait, deselect and patch, then read back
            [0:34]: begin
               repeat ($urandom_range(0, 3)) knob_update(3'($urandom), 12'($urandom));
               repeat ($urandom_range(0, 2)) bus_read(pick_read_address());
               bus_read({1'($urandom), ALIAS_LO});
               bus_read({1'($urandom), ALIAS_HI});
               repeat ($urandom_range(0, 2)) bus_sample(16'($urandom), 1'b0);
               bus_sample(16'($urandom), 1'b1);
               repeat ($urandom_range(1, 2)) bus_read({1'($urandom), knob_byte_address()});
            end
            [35:69]: bus_read(pick_read_address());
            [70:79]: begin
               bus_sample(16'($urandom), 1'b1);
               if ($urandom_range(0, 1)) bus_read(pick_read_address());
            end
            [80:87]: knob_update(3'($urandom), 12'($urandom));
            [88:95]: store_load(15'($urandom), 8'($urandom));
            default: unused_op();
         endcase
      end
      drain();
   endtask

   initial begin
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.op              <= OP_BUS;
      req_chan.bus_address     <= 16'h0000;
      req_chan.cart_deselected <= 1'b0;
      req_chan.knob_channel    <= 3'd0;
      req_chan.knob_sample     <= 12'd0;
      req_chan.load_address    <= 15'd0;
      req_chan.load_data       <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Boot: ignore wrong vectors and the select line, then serve both bytes
      unused_op();
      bus_sample(16'h1234, 1'b1);
      bus_sample(VEC_HI_ADDR, 1'b0);
      bus_sample(VEC_LO_ADDR, 1'b1);
      bus_sample(16'h7FFC, 1'b0);
      bus_sample(VEC_HI_ADDR, 1'b0);

      // Knob extremes and a load past the store
      knob_update(3'd0, 12'h000);
      knob_update(3'd3, 12'hFFF);
      knob_update(3'd4, 12'h000);
      knob_update(3'd7, 12'hFFF);
      store_load(15'h7FFF, 8'hFF);

      // Range edges, held offsets, deselect while serving
      bus_read(16'h0000);
      bus_read(16'hCFFE);
      bus_sample(16'h4FFF, 1'b0);
      bus_sample(16'hFFFF, 1'b0);
      bus_sample(16'h1000, 1'b1);
      bus_read(16'h8000);

      // Alias pair, ignored selects while waiting, patch on deselect
      bus_read({1'b0, ALIAS_LO});
      bus_read({1'b1, ALIAS_HI});
      bus_sample(16'h0000, 1'b0);
      bus_sample(16'hFFFF, 1'b1);
      for (int k = 0; k < 4; k++) begin
         loaded[pitch_base(2'(k))]      = 1'b1;
         loaded[pitch_base(2'(k)) + 1]  = 1'b1;
         loaded[volume_base(2'(k))]     = 1'b1;
         loaded[volume_base(2'(k)) + 1] = 1'b1;
      end
      bus_read({1'b0, pitch_base(2'd0)});
      bus_read({1'b0, pitch_base(2'd0) + 15'd1});
      bus_read({1'b1, pitch_base(2'd3)});
      bus_read({1'b0, volume_base(2'd0)});
      bus_read({1'b1, volume_base(2'd3) + 15'd1});
      drain();

      run_phase(0, 0);
      run_phase(86, 0);
      run_phase(0, 86);
      run_phase(15, 15);
      stall_pct = 0;
      drain();

      $display("Run covered %0d requests: %0d bus samples, %0d knob updates, %0d loads,",
               total_sent, sent_by_op[OP_BUS], sent_by_op[OP_KNOB], sent_by_op[OP_LOAD]);
      $display("%0d unused ops; knob patch rewrites checked: %0d, over all gap mixes",
               sent_by_op[OP_UNUSED], patches_seen);
      if (mismatch_count == 0) begin
         $display("tb_cartridge_rom_responder_with_knob_patch: PASS");
      end else begin
         $display("tb_cartridge_rom_responder_with_knob_patch: FAIL");
      end
      $finish;
   end

endmodule
